// ===== src/priority_source_field_arbiter_top_assert.svh =====
// Assertion macros for the priority source field arbiter.
// Needs clk_i and rst_ni in the scope that uses them.
`ifndef PRIORITY_SOURCE_FIELD_ARBITER_TOP_ASSERT_SVH
`define PRIORITY_SOURCE_FIELD_ARBITER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define PSFARB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("psfarb assertion failed");
`define PSFARB_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("psfarb reset assertion failed");
`else
`define PSFARB_ASSERT(lbl, prop)
`define PSFARB_ASSERT_RST(lbl, prop)
`endif
`endif

// ===== src/psfarb_pkg.sv =====
// Shared types, constants and the rank lookup of the priority source field arbiter.
// No dependencies.
package psfarb_pkg;

  localparam int NUM_FIELDS    = 32;
  localparam int FIELD_AW      = (NUM_FIELDS > 1) ? $clog2(NUM_FIELDS) : 1;
  localparam int PRIO_SLOTS    = 4;
  localparam int NUM_SLOT_REGS = 4;
  localparam int RANK_W        = $clog2(PRIO_SLOTS + 1);
  localparam logic [RANK_W-1:0] RANK_LOWEST = RANK_W'(PRIO_SLOTS);

  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 72;
  localparam int CFG_DATA_W = 32;

  localparam logic [2:0] SRC_NONE = 3'd0;
  localparam logic [2:0] SRC_DEMO = 3'd1;
  localparam logic [2:0] SRC_SIGK = 3'd2;
  localparam logic [2:0] SRC_WIFI = 3'd3;
  localparam logic [2:0] SRC_BUS  = 3'd4;

  localparam logic OP_PUBLISH = 1'b0;
  localparam logic OP_READ    = 1'b1;

  typedef enum logic [2:0] {
    REG_SLOT_FIRST  = 3'd0,
    REG_SLOT_SECOND = 3'd1,
    REG_SLOT_THIRD  = 3'd2,
    REG_SLOT_FOURTH = 3'd3,
    REG_TMO_BUS     = 3'd4,
    REG_TMO_WIFI    = 3'd5,
    REG_TMO_SIGK    = 3'd6,
    REG_TMO_DEMO    = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [NUM_SLOT_REGS-1:0][2:0] slot;
    logic [31:0] tmo_bus;
    logic [31:0] tmo_wifi;
    logic [31:0] tmo_sigk;
    logic [31:0] tmo_demo;
  } cfg_t;

  typedef struct packed {
    logic [63:0] value;
    logic [31:0] time_ms;
    logic [2:0]  owner;
  } entry_t;

  typedef struct packed {
    logic        op;
    logic [4:0]  field_index;
    logic [2:0]  source;
    logic [31:0] now_ms;
    logic [63:0] value;
    logic [31:0] read_timeout_ms;
  } item_t;

  typedef struct packed {
    logic        take;
    logic        fresh;
  } verdict_t;

  function automatic logic [RANK_W-1:0] rank_for(input logic [2:0] src,
                                                 input logic [NUM_SLOT_REGS-1:0][2:0] slot);
    logic [RANK_W-1:0] r;
    logic              stop;
    r    = RANK_LOWEST;
    stop = 1'b0;
    if (src != SRC_NONE) begin
      for (int i = 0; i < PRIO_SLOTS; i++) begin
        if (!stop) begin
          if (slot[i] == src) begin
            r    = RANK_W'(i);
            stop = 1'b1;
          end else if (slot[i] == SRC_NONE) begin
            stop = 1'b1;
          end
        end
      end
    end
    return r;
  endfunction

endpackage

// ===== src/psfarb_cfg.sv =====
// Configuration registers: priority slots and per-source timeouts.
// Depends on psfarb_pkg.
module psfarb_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [2:0]                       cfg_idx_i,
  input  logic [psfarb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output psfarb_pkg::cfg_t                 cfg_o
);
  import psfarb_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_SLOT_FIRST:  cfg_d.slot[0]  = cfg_data_i[2:0];
        REG_SLOT_SECOND: cfg_d.slot[1]  = cfg_data_i[2:0];
        REG_SLOT_THIRD:  cfg_d.slot[2]  = cfg_data_i[2:0];
        REG_SLOT_FOURTH: cfg_d.slot[3]  = cfg_data_i[2:0];
        REG_TMO_BUS:     cfg_d.tmo_bus  = cfg_data_i[31:0];
        REG_TMO_WIFI:    cfg_d.tmo_wifi = cfg_data_i[31:0];
        REG_TMO_SIGK:    cfg_d.tmo_sigk = cfg_data_i[31:0];
        REG_TMO_DEMO:    cfg_d.tmo_demo = cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slot[0]  <= SRC_BUS;
      cfg_q.slot[1]  <= SRC_WIFI;
      cfg_q.slot[2]  <= SRC_SIGK;
      cfg_q.slot[3]  <= SRC_DEMO;
      cfg_q.tmo_bus  <= 32'd5000;
      cfg_q.tmo_wifi <= 32'd5000;
      cfg_q.tmo_sigk <= 32'd5000;
      cfg_q.tmo_demo <= 32'd5000;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/psfarb_store.sv =====
// Field table: one synchronous memory of value, time and owner per field.
// Per-entry valid bits make unwritten entries read as zero. Depends on psfarb_pkg.
module psfarb_store (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              rd_en_i,
  input  logic [psfarb_pkg::FIELD_AW-1:0]   rd_addr_i,
  output psfarb_pkg::entry_t                rd_data_o,
  input  logic                              wr_en_i,
  input  logic [psfarb_pkg::FIELD_AW-1:0]   wr_addr_i,
  input  psfarb_pkg::entry_t                wr_data_i
);
  import psfarb_pkg::*;

  entry_t                  mem [NUM_FIELDS];
  logic [NUM_FIELDS-1:0]   valid_q;
  entry_t                  rd_data_q;
  logic                    rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

// ===== src/psfarb_judge.sv =====
// Publish arbitration and read freshness for one fetched entry.
// Depends on psfarb_pkg.
module psfarb_judge (
  input  psfarb_pkg::cfg_t     cfg_i,
  input  psfarb_pkg::item_t    item_i,
  input  psfarb_pkg::entry_t   entry_i,
  output psfarb_pkg::verdict_t verdict_o
);
  import psfarb_pkg::*;

  logic [31:0]       age;
  logic [31:0]       owner_tmo;
  logic [RANK_W-1:0] rank_in;
  logic [RANK_W-1:0] rank_own;
  logic              src_ok;

  assign age      = item_i.now_ms - entry_i.time_ms;
  assign rank_in  = rank_for(item_i.source, cfg_i.slot);
  assign rank_own = rank_for(entry_i.owner, cfg_i.slot);
  assign src_ok   = (item_i.source != SRC_NONE) && (item_i.source <= SRC_BUS);

  always_comb begin
    case (entry_i.owner)
      SRC_DEMO: owner_tmo = cfg_i.tmo_demo;
      SRC_SIGK: owner_tmo = cfg_i.tmo_sigk;
      SRC_WIFI: owner_tmo = cfg_i.tmo_wifi;
      SRC_BUS:  owner_tmo = cfg_i.tmo_bus;
      default:  owner_tmo = '0;
    endcase
  end

  assign verdict_o.take = src_ok &&
                          ((entry_i.owner == SRC_NONE) || (rank_in <= rank_own) ||
                           (owner_tmo == '0) || (age >= owner_tmo));

  assign verdict_o.fresh = (entry_i.owner != SRC_NONE) &&
                           (item_i.read_timeout_ms != '0) &&
                           (age < item_i.read_timeout_ms);

endmodule

// ===== src/priority_source_field_arbiter_top.sv =====
// Priority source field arbiter: field table with source failover by rank and timeout.
// Depends on psfarb_pkg, psfarb_cfg, psfarb_store, psfarb_judge.
// Timing: the taken word and its table read are registered, then the result word is registered in S_EVAL.
// A new word is taken only in S_IDLE with the output register free, after the last one's write-back.
// Reset: table reads as zero (per-entry valid bits), config to its defaults,
// no clearing pass; the block takes words right after reset.
module priority_source_field_arbiter_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // field_index[4:0], source[7:5], now_ms[39:8], value[103:40], read_timeout_ms[135:104]
  input  logic [psfarb_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // op[0]
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // accepted[0], read_value[64:1], read_source[67:65], read_fresh[68], zero[71:69]
  output logic [psfarb_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input  logic                                cfg_we_i,
  input  logic [2:0]                          cfg_idx_i,
  input  logic [psfarb_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import psfarb_pkg::*;
  `include "priority_source_field_arbiter_top_assert.svh"

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EVAL = 2'b10
  } state_e;

  state_e   state_q, state_d;
  item_t    rec_q, in_item;
  cfg_t     cfg;
  entry_t   entry, wr_entry;
  verdict_t verdict;
  logic     in_fire;
  logic     in_range;
  logic     pub_ok;
  logic     mem_we;
  logic     out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;

  assign in_item.op              = s_axis_tuser;
  assign in_item.field_index     = s_axis_tdata[4:0];
  assign in_item.source          = s_axis_tdata[7:5];
  assign in_item.now_ms          = s_axis_tdata[39:8];
  assign in_item.value           = s_axis_tdata[103:40];
  assign in_item.read_timeout_ms = s_axis_tdata[135:104];

  assign s_axis_tready = (state_q == S_IDLE) && (!out_valid_q || m_axis_tready);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  psfarb_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  psfarb_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_fire),
    .rd_addr_i (in_item.field_index[FIELD_AW-1:0]),
    .rd_data_o (entry),
    .wr_en_i   (mem_we),
    .wr_addr_i (rec_q.field_index[FIELD_AW-1:0]),
    .wr_data_i (wr_entry)
  );

  psfarb_judge u_judge (
    .cfg_i     (cfg),
    .item_i    (rec_q),
    .entry_i   (entry),
    .verdict_o (verdict)
  );

  assign in_range = 32'(rec_q.field_index) < 32'(NUM_FIELDS);
  assign pub_ok   = (rec_q.op == OP_PUBLISH) && in_range && verdict.take;
  assign mem_we   = (state_q == S_EVAL) && pub_ok;

  assign wr_entry.value   = rec_q.value;
  assign wr_entry.time_ms = rec_q.now_ms;
  assign wr_entry.owner   = rec_q.source;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        state_d     = S_IDLE;
        out_valid_d = 1'b1;
        out_data_d  = '0;
        out_data_d[0] = pub_ok;
        if ((rec_q.op == OP_READ) && in_range) begin
          out_data_d[64:1]  = entry.value;
          out_data_d[67:65] = entry.owner;
          out_data_d[68]    = verdict.fresh;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rec_q <= in_item;
    end
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  `PSFARB_ASSERT(a_fire_to_eval, in_fire |=> (state_q == S_EVAL))
  `PSFARB_ASSERT(a_eval_out_free, (state_q == S_EVAL) |-> !out_valid_q)
  `PSFARB_ASSERT(a_write_is_publish, mem_we |-> (rec_q.op == OP_PUBLISH) && in_range)
  `PSFARB_ASSERT(a_result_after_eval, $rose(m_axis_tvalid) |-> $past(state_q == S_EVAL))
  `PSFARB_ASSERT_RST(a_reset_quiet, !rst_ni |=> !m_axis_tvalid && (state_q == S_IDLE))

endmodule

// ===== test/priority_source_field_arbiter_top_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for priority_source_field_arbiter_top: publish/read words against a
// local field-table arbiter, priority list and timeouts rewritten between phases.
// Depends on psfarb_pkg and the RTL only.
module priority_source_field_arbiter_top_tb;
  import psfarb_pkg::*;

  localparam int RANK_UNLISTED = 255;
  localparam int HOLD_AT       = 120;
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 3000;
  localparam int PHASES        = 10;
  localparam int PHASE_WORDS   = 53;

  typedef enum logic [1:0] {ACT_WORD, ACT_REG, ACT_DRAIN} action_e;

  typedef struct {
    action_e     kind;
    item_t       word;
    reg_idx_e    idx;
    logic [31:0] data;
  } action_t;

  typedef struct packed {
    logic        accepted;
    logic [63:0] rd_value;
    logic [2:0]  rd_source;
    logic        rd_fresh;
  } outcome_t;

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  s_axis_tvalid  = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata   = '0;
  logic                  s_axis_tuser   = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we_i       = 1'b0;
  logic [2:0]            cfg_idx_i      = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i     = '0;

  // arbiter state as predicted
  logic [2:0]  slot_cfg  [4];
  logic [31:0] tmo_cfg   [8];
  logic [63:0] fld_value [NUM_FIELDS];
  logic [31:0] fld_time  [NUM_FIELDS];
  logic [2:0]  fld_owner [NUM_FIELDS];

  action_t  plan_q[$];
  outcome_t outcome_q[$];

  int    words_planned = 0;
  int    words_taken   = 0;
  int    results_seen  = 0;
  int    fail_cnt      = 0;
  int    idle_cycles   = 0;
  int    send_wait     = 0;
  int    recv_wait     = 0;
  bit    send_idle_en  = 1'b1;
  bit    recv_idle_en  = 1'b1;
  item_t offered_word;
  action_t head;
  logic  valid_n;
  logic  we_n;

  priority_source_field_arbiter_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  function automatic int src_rank(logic [2:0] src);
    int r;
    bit stop;
    r    = RANK_UNLISTED;
    stop = 1'b0;
    if (src != SRC_NONE) begin
      for (int i = 0; i < PRIO_SLOTS; i++) begin
        if (!stop) begin
          if (slot_cfg[i] == src) begin
            r    = i;
            stop = 1'b1;
          end else if (slot_cfg[i] == SRC_NONE) begin
            stop = 1'b1;
          end
        end
      end
    end
    return r;
  endfunction

  function automatic bit may_replace(logic [2:0] src, logic [2:0] owner,
                                     logic [31:0] owned_at, logic [31:0] now);
    logic [31:0] hold;
    logic [31:0] age;
    age  = now - owned_at;
    hold = tmo_cfg[owner];
    if (src == SRC_NONE || src > SRC_BUS) return 1'b0;
    if (owner == SRC_NONE) return 1'b1;
    if (src_rank(src) <= src_rank(owner)) return 1'b1;
    return (hold == 32'd0) || (age >= hold);
  endfunction

  function automatic void arbitrate_word(item_t w);
    outcome_t    o;
    logic [2:0]  owner;
    logic [31:0] age;
    o     = '0;
    owner = fld_owner[w.field_index];
    age   = w.now_ms - fld_time[w.field_index];
    if (w.op == OP_PUBLISH) begin
      if (may_replace(w.source, owner, fld_time[w.field_index], w.now_ms)) begin
        fld_value[w.field_index] = w.value;
        fld_time[w.field_index]  = w.now_ms;
        fld_owner[w.field_index] = w.source;
        o.accepted = 1'b1;
      end
    end else begin
      o.rd_value  = fld_value[w.field_index];
      o.rd_source = owner;
      o.rd_fresh  = (owner != SRC_NONE) && (w.read_timeout_ms != 32'd0) &&
                    (age < w.read_timeout_ms);
    end
    outcome_q.push_back(o);
  endfunction

  function automatic void apply_reg(reg_idx_e idx, logic [31:0] d);
    case (idx)
      REG_SLOT_FIRST, REG_SLOT_SECOND, REG_SLOT_THIRD, REG_SLOT_FOURTH: slot_cfg[idx] = d[2:0];
      REG_TMO_BUS:  tmo_cfg[SRC_BUS]  = d;
      REG_TMO_WIFI: tmo_cfg[SRC_WIFI] = d;
      REG_TMO_SIGK: tmo_cfg[SRC_SIGK] = d;
      REG_TMO_DEMO: tmo_cfg[SRC_DEMO] = d;
      default: ;
    endcase
  endfunction

  function automatic void flag_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t ERROR %s: expected %h, actual %h", $time, name, want, got);
      fail_cnt++;
    end
  endfunction

  function automatic void check_result(logic [OUT_DATA_W-1:0] d);
    outcome_t want;
    if (outcome_q.size() == 0) begin
      $display("%0t ERROR unexpected word: expected none, actual %h", $time, d);
      fail_cnt++;
    end else begin
      want = outcome_q.pop_front();
      flag_field("accepted", want.accepted, d[0]);
      flag_field("read_value", want.rd_value, d[64:1]);
      flag_field("read_source", want.rd_source, d[67:65]);
      flag_field("read_fresh", want.rd_fresh, d[68]);
    end
  endfunction

  function automatic int draw_wait(bit en);
    return en ? $urandom_range(0, 12) : 0;
  endfunction

  function automatic void plan_word(logic op, logic [4:0] fld, logic [2:0] src,
                                    logic [31:0] now, logic [63:0] val, logic [31:0] rto);
    action_t a;
    a.kind                 = ACT_WORD;
    a.word.op              = op;
    a.word.field_index     = fld;
    a.word.source          = src;
    a.word.now_ms          = now;
    a.word.value           = val;
    a.word.read_timeout_ms = rto;
    a.idx                  = REG_SLOT_FIRST;
    a.data                 = '0;
    plan_q.push_back(a);
    words_planned++;
  endfunction

  function automatic void plan_reg(reg_idx_e idx, logic [31:0] d);
    action_t a;
    a.kind = ACT_REG;
    a.word = '0;
    a.idx  = idx;
    a.data = d;
    plan_q.push_back(a);
  endfunction

  function automatic void plan_drain();
    action_t a;
    a.kind = ACT_DRAIN;
    a.word = '0;
    a.idx  = REG_SLOT_FIRST;
    a.data = '0;
    plan_q.push_back(a);
  endfunction

  function automatic void plan_config(logic [2:0] s0, logic [2:0] s1, logic [2:0] s2,
                                      logic [2:0] s3, logic [31:0] t_bus,
                                      logic [31:0] t_wifi, logic [31:0] t_sigk,
                                      logic [31:0] t_demo);
    plan_reg(REG_SLOT_FIRST, {29'd0, s0});
    plan_reg(REG_SLOT_SECOND, {29'd0, s1});
    plan_reg(REG_SLOT_THIRD, {29'd0, s2});
    plan_reg(REG_SLOT_FOURTH, {29'd0, s3});
    plan_reg(REG_TMO_BUS, t_bus);
    plan_reg(REG_TMO_WIFI, t_wifi);
    plan_reg(REG_TMO_SIGK, t_sigk);
    plan_reg(REG_TMO_DEMO, t_demo);
  endfunction

  function automatic logic [2:0] pick_slot();
    return ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(1, 4));
  endfunction

  function automatic logic [31:0] pick_timeout();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2, 3:    return $urandom_range(1, 300);
      4:       return $urandom_range(300, 5000);
      default: return $urandom;
    endcase
  endfunction

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      cfg_we_i      <= 1'b0;
      send_wait = 0;
    end else begin
      valid_n = s_axis_tvalid && !s_axis_tready;
      we_n    = 1'b0;
      if (s_axis_tvalid && s_axis_tready) begin
        arbitrate_word(offered_word);
        words_taken++;
        if ($urandom_range(0, 39) == 0) send_idle_en = !send_idle_en;
        send_wait = draw_wait(send_idle_en);
      end
      if (!valid_n) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (plan_q.size() > 0) begin
          case (plan_q[0].kind)
            ACT_WORD: begin
              head         = plan_q.pop_front();
              offered_word = head.word;
              valid_n      = 1'b1;
              s_axis_tdata <= {head.word.read_timeout_ms, head.word.value, head.word.now_ms,
                               head.word.source, head.word.field_index};
              s_axis_tuser <= head.word.op;
            end
            ACT_REG: begin
              if (outcome_q.size() == 0) begin
                head = plan_q.pop_front();
                we_n = 1'b1;
                cfg_idx_i  <= head.idx;
                cfg_data_i <= head.data;
                apply_reg(head.idx, head.data);
              end
            end
            default: begin
              if (outcome_q.size() == 0) head = plan_q.pop_front();
            end
          endcase
        end
      end
      s_axis_tvalid <= valid_n;
      cfg_we_i      <= we_n;
    end
  end

  // receiver, one long hold-off after HOLD_AT results
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_result(m_axis_tdata);
        results_seen++;
        if ($urandom_range(0, 39) == 0) recv_idle_en = !recv_idle_en;
        recv_wait = (results_seen == HOLD_AT) ? HOLD_CYCLES : draw_wait(recv_idle_en);
      end else if (recv_wait > 0) begin
        recv_wait--;
      end
      m_axis_tready <= (recv_wait == 0);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && !((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                    cfg_we_i)) begin
      idle_cycles++;
      if (idle_cycles == STALL_LIMIT) begin
        $display("priority_source_field_arbiter_top verification failed");
        $finish;
      end
    end else begin
      idle_cycles = 0;
    end
  end

  initial begin
    logic [31:0] t_ms;
    logic [31:0] rto;
    int          step_max;
    int          hot_base;
    slot_cfg[0] = SRC_BUS;
    slot_cfg[1] = SRC_WIFI;
    slot_cfg[2] = SRC_SIGK;
    slot_cfg[3] = SRC_DEMO;
    for (int i = 0; i < 8; i++) tmo_cfg[i] = (i >= 1 && i <= 4) ? 32'd5000 : 32'd0;
    for (int i = 0; i < NUM_FIELDS; i++) begin
      fld_value[i] = '0;
      fld_time[i]  = '0;
      fld_owner[i] = SRC_NONE;
    end

    // reset priorities and timeouts
    plan_word(OP_READ, 5'd0, SRC_NONE, 32'd0, '0, 32'hFFFF_FFFF);
    plan_word(OP_PUBLISH, 5'd0, SRC_NONE, 32'd10, 64'h1, '0);
    plan_word(OP_PUBLISH, 5'd0, 3'd5, 32'd10, 64'h2, '0);
    plan_word(OP_PUBLISH, 5'd0, 3'd6, 32'd10, 64'h3, '0);
    plan_word(OP_PUBLISH, 5'd0, 3'd7, 32'd10, 64'h4, '0);
    plan_word(OP_PUBLISH, 5'd0, SRC_DEMO, 32'd100, '1, '0);
    plan_word(OP_PUBLISH, 5'd0, SRC_BUS, 32'd200, '0, '0);
    plan_word(OP_PUBLISH, 5'd0, SRC_DEMO, 32'd300, 64'h5, '0);
    plan_word(OP_PUBLISH, 5'd0, SRC_WIFI, 32'd5199, 64'h6, '0);
    plan_word(OP_PUBLISH, 5'd0, SRC_WIFI, 32'd5200, 64'h7, '0);
    plan_word(OP_PUBLISH, 5'd0, SRC_WIFI, 32'd5201, 64'h8, '0);
    plan_word(OP_READ, 5'd0, SRC_NONE, 32'd5201, '0, 32'd1);
    plan_word(OP_READ, 5'd0, SRC_NONE, 32'd5202, '0, 32'd1);
    plan_word(OP_READ, 5'd0, SRC_NONE, 32'd5201, '0, 32'd0);
    // age measured across the time wrap
    plan_word(OP_PUBLISH, 5'd31, SRC_SIGK, 32'hFFFF_FFF0, 64'h5555_5555_5555_5555, '0);
    plan_word(OP_PUBLISH, 5'd31, SRC_DEMO, 32'h0000_1377, 64'hAAAA_AAAA_AAAA_AAAA, '0);
    plan_word(OP_PUBLISH, 5'd31, SRC_DEMO, 32'h0000_1378, 64'hAAAA_AAAA_AAAA_AAAA, '0);
    plan_word(OP_READ, 5'd31, SRC_NONE, 32'hFFFF_FFFF, '0, 32'hFFFF_FFFF);
    // short list: unlisted sources rank equal and lowest
    plan_config(SRC_SIGK, SRC_NONE, SRC_BUS, SRC_DEMO, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'd0);
    plan_word(OP_PUBLISH, 5'd5, SRC_WIFI, 32'd10, 64'h10, '0);
    plan_word(OP_PUBLISH, 5'd5, SRC_DEMO, 32'd11, 64'h11, '0);
    plan_word(OP_PUBLISH, 5'd5, SRC_SIGK, 32'd12, 64'h12, '0);
    plan_word(OP_PUBLISH, 5'd5, SRC_BUS, 32'd13, 64'h13, '0);
    // codes above four do not end the list; zero timeout lets anyone in
    plan_config(3'd7, 3'd5, SRC_DEMO, SRC_BUS, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
    plan_word(OP_PUBLISH, 5'd7, SRC_BUS, 32'd0, 64'h20, '0);
    plan_word(OP_PUBLISH, 5'd7, SRC_WIFI, 32'd1, 64'h21, '0);
    plan_word(OP_PUBLISH, 5'd7, SRC_SIGK, 32'd2, 64'h22, '0);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: plan_config(SRC_NONE, SRC_NONE, SRC_NONE, SRC_NONE, '1, '1, '1, '1);
        1: plan_config(3'd7, 3'd6, 3'd5, 3'd7, '0, '0, '0, '0);
        2: plan_config(SRC_BUS, SRC_WIFI, SRC_SIGK, SRC_DEMO, 32'd5000, 32'd5000, 32'd5000,
                       32'd5000);
        default: plan_config(pick_slot(), pick_slot(), pick_slot(), pick_slot(),
                             pick_timeout(), pick_timeout(), pick_timeout(), pick_timeout());
      endcase
      case ($urandom_range(0, 2))
        0:       step_max = 20;
        1:       step_max = 300;
        default: step_max = 6000;
      endcase
      t_ms     = (p % 2 == 1) ? 32'hFFFF_FFFF - $urandom_range(0, 2000) : $urandom;
      hot_base = $urandom_range(0, NUM_FIELDS - 4);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if ($urandom_range(0, 99) < 12) begin
          plan_word(1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)),
                    3'($urandom_range(0, 7)), $urandom, {$urandom, $urandom}, $urandom);
        end else begin
          t_ms = t_ms + $urandom_range(0, step_max);
          if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 5))
              0:       rto = 32'd0;
              1:       rto = 32'hFFFF_FFFF;
              default: rto = $urandom_range(1, 2 * step_max + 1);
            endcase
            plan_word(OP_READ, 5'(hot_base + $urandom_range(0, 3)), SRC_NONE, t_ms, '0, rto);
          end else begin
            plan_word(OP_PUBLISH, 5'(hot_base + $urandom_range(0, 3)),
                      3'($urandom_range(1, 4)), t_ms, {$urandom, $urandom}, '0);
          end
        end
        if ($urandom_range(0, 59) == 0) plan_drain();
      end
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (!(words_taken == words_planned && outcome_q.size() == 0)) @(negedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("priority_source_field_arbiter_top verification clean");
    end else begin
      $display("priority_source_field_arbiter_top verification failed");
    end
    $finish;
  end

endmodule
